// ===== sv/edpm_pkg.sv =====
// ----------------------------------------------------------------------------
// edpm_pkg
// shared types, widths and helpers for the exact drift particle map
// ----------------------------------------------------------------------------
package edpm_pkg;

  localparam int FRAC_BITS = 24;
  localparam int W         = 32;
  localparam int LEN_W     = 31;
  localparam int SQ_STEPS  = 32;
  localparam int RAD_W     = 2 * SQ_STEPS;
  localparam int REM_W     = SQ_STEPS + 2;
  localparam int Q_W       = 41;
  localparam int NUM_W     = W + LEN_W;
  localparam int HI_W      = NUM_W - Q_W;
  localparam int SUM_W     = Q_W + 2;
  localparam int NLANE     = 3;

  localparam int LANE_X  = 0;
  localparam int LANE_Y  = 1;
  localparam int LANE_CT = 2;

  localparam logic [W:0]     ONE  = (W + 1)'(1) << FRAC_BITS;
  localparam logic [Q_W-1:0] QCAP = Q_W'(1) << (Q_W - 1);

  typedef struct packed {
    logic signed [W-1:0] x;
    logic signed [W-1:0] px;
    logic signed [W-1:0] y;
    logic signed [W-1:0] py;
    logic signed [W-1:0] delta;
    logic signed [W-1:0] ct;
    logic                lost;
    logic                last;
  } item_t;

  typedef struct packed {
    logic [RAD_W-1:0]    rad;
    logic [REM_W-1:0]    rem;
    logic [SQ_STEPS-1:0] root;
  } sqrt_t;

  typedef struct packed {
    logic [W-1:0]   rem;
    logic [Q_W-1:0] nq;
    logic           ovf;
  } lane_t;

  typedef struct packed {
    lane_t [NLANE-1:0] lane;
    logic  [W-1:0]     s;
    logic  [NLANE-1:0] neg;
  } divw_t;

  // magnitude of a 33-bit signed value, fits in 32 bits for all our inputs
  function automatic logic [W-1:0] mag33(input logic [W:0] v);
    logic [W:0] n;
    n = -v;
    return v[W] ? n[W-1:0] : v[W-1:0];
  endfunction

  function automatic logic [W:0] sext33(input logic [W-1:0] v);
    return {v[W-1], v};
  endfunction

  function automatic logic [W-1:0] sat32(input logic [SUM_W-1:0] v);
    logic hi_ok;
    hi_ok = (v[SUM_W-1:W-1] == '0) || (v[SUM_W-1:W-1] == '1);
    if (hi_ok) return v[W-1:0];
    return v[SUM_W-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
  endfunction

endpackage

// ===== sv/edpm_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// edpm_sqrt_cell
// one root bit of the digit-by-digit square root, with its own stage register
// ----------------------------------------------------------------------------
module edpm_sqrt_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            valid_i,
  output logic            ready_o,
  input  edpm_pkg::item_t item_i,
  input  edpm_pkg::sqrt_t sq_i,
  output logic            valid_o,
  input  logic            ready_i,
  output edpm_pkg::item_t item_o,
  output edpm_pkg::sqrt_t sq_o
);
  import edpm_pkg::*;

  logic [REM_W+1:0] t;
  logic [REM_W+1:0] trial;
  logic [REM_W+1:0] diff;
  logic             ge;

  assign t       = {sq_i.rem, sq_i.rad[RAD_W-1 -: 2]};
  assign trial   = {2'b00, sq_i.root, 2'b01};
  assign diff    = t - trial;
  assign ge      = t >= trial;
  assign ready_o = !valid_o || ready_i;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_o <= 1'b0;
    end else if (ready_o) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      item_o     <= item_i;
      sq_o.rad   <= {sq_i.rad[RAD_W-3:0], 2'b00};
      sq_o.rem   <= ge ? diff[REM_W-1:0] : t[REM_W-1:0];
      sq_o.root  <= {sq_i.root[SQ_STEPS-2:0], ge};
    end
  end

endmodule

// ===== sv/edpm_div_cell.sv =====
// ----------------------------------------------------------------------------
// edpm_div_cell
// one quotient bit of three restoring divisions sharing a divisor
// ----------------------------------------------------------------------------
module edpm_div_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            valid_i,
  output logic            ready_o,
  input  edpm_pkg::item_t item_i,
  input  edpm_pkg::divw_t dw_i,
  output logic            valid_o,
  input  logic            ready_i,
  output edpm_pkg::item_t item_o,
  output edpm_pkg::divw_t dw_o
);
  import edpm_pkg::*;

  divw_t dw_next;

  always_comb begin
    logic [W:0] t;
    logic [W:0] diff;
    logic       ge;
    dw_next = dw_i;
    for (int i = 0; i < NLANE; i++) begin
      t    = {dw_i.lane[i].rem, dw_i.lane[i].nq[Q_W-1]};
      diff = t - {1'b0, dw_i.s};
      ge   = t >= {1'b0, dw_i.s};
      dw_next.lane[i].rem = ge ? diff[W-1:0] : t[W-1:0];
      dw_next.lane[i].nq  = {dw_i.lane[i].nq[Q_W-2:0], ge};
    end
  end

  assign ready_o = !valid_o || ready_i;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_o <= 1'b0;
    end else if (ready_o) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      item_o <= item_i;
      dw_o   <= dw_next;
    end
  end

endmodule

// ===== sv/exact_drift_particle_map.sv =====
// ----------------------------------------------------------------------------
// exact_drift_particle_map
// exact drift of one particle through a field-free section, Q8.24 fixed point
// ----------------------------------------------------------------------------
//  channel   direction  handshake                  payload
//  input     in         in_valid / in_ready        x,px,y,py,delta,ct,lost,last _in
//  output    out        out_valid / out_ready      x,px,y,py,delta,ct,lost,last _out
//  config    in         cfg_wr_en (no wait)        cfg_wr_data = drift length
//
//  one transfer per cycle sustained while out_ready stays high; from input
//  transfer to output transfer an item passes 2 square/compare stages, 32 square
//  root cells, 2 multiply and setup stages, 41 divider cells and the output
//  register; each stage holds its item when the next one is full, bubbles close
//  up, so input transfers go on while a result waits at the output
//  rst clears every stage valid bit and sets the drift length to zero
// ----------------------------------------------------------------------------
module exact_drift_particle_map (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [edpm_pkg::W-1:0] x_in,
  input  logic signed [edpm_pkg::W-1:0] px_in,
  input  logic signed [edpm_pkg::W-1:0] y_in,
  input  logic signed [edpm_pkg::W-1:0] py_in,
  input  logic signed [edpm_pkg::W-1:0] delta_in,
  input  logic signed [edpm_pkg::W-1:0] ct_in,
  input  logic                          lost_in,
  input  logic                          last_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [edpm_pkg::W-1:0] x_out,
  output logic signed [edpm_pkg::W-1:0] px_out,
  output logic signed [edpm_pkg::W-1:0] y_out,
  output logic signed [edpm_pkg::W-1:0] py_out,
  output logic signed [edpm_pkg::W-1:0] delta_out,
  output logic signed [edpm_pkg::W-1:0] ct_out,
  output logic                          lost_out,
  output logic                          last_out,
  input  logic                          cfg_wr_en,
  input  logic [edpm_pkg::LEN_W-1:0]    cfg_wr_data
);
  import edpm_pkg::*;

  localparam int DIV_STEPS = Q_W;

  // drift length register
  logic [LEN_W-1:0] drift_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      drift_length <= '0;
    end else if (cfg_wr_en) begin
      drift_length <= cfg_wr_data;
    end
  end

  // ---------------- stage 1: squares of |1+delta|, |px|, |py|
  logic          f1_v;
  logic          f1_rdy;
  item_t         f1_item;
  logic [RAD_W-1:0] f1_a2;
  logic [RAD_W-1:0] f1_x2;
  logic [RAD_W-1:0] f1_y2;
  logic [W-1:0]  in_dmag;
  logic [W-1:0]  in_pxmag;
  logic [W-1:0]  in_pymag;
  logic          f2_rdy;

  assign in_dmag  = mag33(sext33(delta_in) + ONE);
  assign in_pxmag = mag33(sext33(px_in));
  assign in_pymag = mag33(sext33(py_in));
  assign f1_rdy   = !f1_v || f2_rdy;
  assign in_ready = f1_rdy;

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_v <= 1'b0;
    end else if (f1_rdy) begin
      f1_v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (f1_rdy && in_valid) begin
      f1_item <= '{x: x_in, px: px_in, y: y_in, py: py_in, delta: delta_in,
                   ct: ct_in, lost: lost_in, last: last_in};
      f1_a2   <= RAD_W'(in_dmag) * RAD_W'(in_dmag);
      f1_x2   <= RAD_W'(in_pxmag) * RAD_W'(in_pxmag);
      f1_y2   <= RAD_W'(in_pymag) * RAD_W'(in_pymag);
    end
  end

  // ---------------- stage 2: pz squared and the loss test
  logic          f2_v;
  item_t         f2_item;
  logic [RAD_W-1:0] f2_pz2;
  logic [RAD_W:0]   t2;
  logic [RAD_W:0]   pz2_diff;
  logic          nonpos;

  logic  sq_v   [SQ_STEPS+1];
  logic  sq_rdy [SQ_STEPS+1];
  item_t sq_item[SQ_STEPS+1];
  sqrt_t sq_d   [SQ_STEPS+1];

  assign t2       = {1'b0, f1_x2} + {1'b0, f1_y2};
  assign pz2_diff = {1'b0, f1_a2} - t2;
  assign nonpos   = pz2_diff[RAD_W] || (pz2_diff == '0);
  assign f2_rdy   = !f2_v || sq_rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      f2_v <= 1'b0;
    end else if (f2_rdy) begin
      f2_v <= f1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (f2_rdy && f1_v) begin
      f2_item <= '{x: f1_item.x, px: f1_item.px, y: f1_item.y, py: f1_item.py,
                   delta: f1_item.delta, ct: f1_item.ct,
                   lost: f1_item.lost || nonpos, last: f1_item.last};
      f2_pz2  <= pz2_diff[RAD_W-1:0];
    end
  end

  // ---------------- square root chain, one root bit per cell
  assign sq_v[0]    = f2_v;
  assign sq_item[0] = f2_item;
  assign sq_d[0]    = '{rad: f2_pz2, rem: '0, root: '0};

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    edpm_sqrt_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .valid_i (sq_v[k]),
      .ready_o (sq_rdy[k]),
      .item_i  (sq_item[k]),
      .sq_i    (sq_d[k]),
      .valid_o (sq_v[k+1]),
      .ready_i (sq_rdy[k+1]),
      .item_o  (sq_item[k+1]),
      .sq_o    (sq_d[k+1])
    );
  end

  // ---------------- multiply stage: |num| * drift length
  logic             m_v;
  logic             m_rdy;
  item_t            m_item;
  logic [NUM_W-1:0] m_num [NLANE];
  logic [W-1:0]     m_s;
  logic [NLANE-1:0] m_neg;
  logic [W:0]       sq_d33;
  logic [W-1:0]     sq_root;
  logic             m2_rdy;

  assign sq_root        = sq_d[SQ_STEPS].root;
  assign sq_d33         = sext33(sq_item[SQ_STEPS].delta) + ONE;
  assign m_rdy          = !m_v || m2_rdy;
  assign sq_rdy[SQ_STEPS] = m_rdy;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_v <= 1'b0;
    end else if (m_rdy) begin
      m_v <= sq_v[SQ_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (m_rdy && sq_v[SQ_STEPS]) begin
      m_item         <= sq_item[SQ_STEPS];
      // a tiny positive pz squared still divides by one lsb
      m_s            <= (sq_root == '0) ? W'(1) : sq_root;
      m_num[LANE_X]  <= NUM_W'(mag33(sext33(sq_item[SQ_STEPS].px))) * NUM_W'(drift_length);
      m_num[LANE_Y]  <= NUM_W'(mag33(sext33(sq_item[SQ_STEPS].py))) * NUM_W'(drift_length);
      m_num[LANE_CT] <= NUM_W'(mag33(sq_d33)) * NUM_W'(drift_length);
      m_neg          <= {sq_d33[W], sq_item[SQ_STEPS].py[W-1], sq_item[SQ_STEPS].px[W-1]};
    end
  end

  // ---------------- divider setup: high numerator bits and the clamp test
  logic  m2_v;
  item_t m2_item;
  divw_t m2_dw;
  divw_t m2_next;

  logic  dv_v   [DIV_STEPS+1];
  logic  dv_rdy [DIV_STEPS+1];
  item_t dv_item[DIV_STEPS+1];
  divw_t dv_d   [DIV_STEPS+1];

  always_comb begin
    m2_next     = '0;
    m2_next.s   = m_s;
    m2_next.neg = m_neg;
    for (int i = 0; i < NLANE; i++) begin
      // quotient of 2^41 or more is clamped anyway
      m2_next.lane[i].ovf = W'(m_num[i][NUM_W-1:Q_W]) >= m_s;
      m2_next.lane[i].rem = W'(m_num[i][NUM_W-1:Q_W]);
      m2_next.lane[i].nq  = m_num[i][Q_W-1:0];
    end
  end

  assign m2_rdy = !m2_v || dv_rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      m2_v <= 1'b0;
    end else if (m2_rdy) begin
      m2_v <= m_v;
    end
  end

  always_ff @(posedge clk) begin
    if (m2_rdy && m_v) begin
      m2_item <= m_item;
      m2_dw   <= m2_next;
    end
  end

  // ---------------- divider chain, one quotient bit per cell
  assign dv_v[0]    = m2_v;
  assign dv_item[0] = m2_item;
  assign dv_d[0]    = m2_dw;

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    edpm_div_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .valid_i (dv_v[k]),
      .ready_o (dv_rdy[k]),
      .item_i  (dv_item[k]),
      .dw_i    (dv_d[k]),
      .valid_o (dv_v[k+1]),
      .ready_i (dv_rdy[k+1]),
      .item_o  (dv_item[k+1]),
      .dw_o    (dv_d[k+1])
    );
  end

  // ---------------- output register: signed, clamped, saturating sums
  logic             out_v;
  logic             out_rdy;
  item_t            out_item;
  logic [W-1:0]     out_x;
  logic [W-1:0]     out_y;
  logic [W-1:0]     out_ct;
  logic [Q_W-1:0]   qc   [NLANE];
  logic [SUM_W-1:0] term [NLANE];
  logic [SUM_W-1:0] sum_x;
  logic [SUM_W-1:0] sum_y;
  logic [SUM_W-1:0] sum_ct;
  item_t            fin_item;
  divw_t            fin_dw;

  assign fin_item = dv_item[DIV_STEPS];
  assign fin_dw   = dv_d[DIV_STEPS];

  always_comb begin
    for (int i = 0; i < NLANE; i++) begin
      qc[i]   = (fin_dw.lane[i].ovf || fin_dw.lane[i].nq > QCAP) ? QCAP
                                                                 : fin_dw.lane[i].nq;
      term[i] = fin_dw.neg[i] ? -{2'b00, qc[i]} : {2'b00, qc[i]};
    end
  end

  assign sum_x  = {{(SUM_W-W){fin_item.x[W-1]}}, fin_item.x} + term[LANE_X];
  assign sum_y  = {{(SUM_W-W){fin_item.y[W-1]}}, fin_item.y} + term[LANE_Y];
  assign sum_ct = {{(SUM_W-W){fin_item.ct[W-1]}}, fin_item.ct} + term[LANE_CT]
                  - SUM_W'(drift_length);

  assign out_rdy            = !out_v || out_ready;
  assign dv_rdy[DIV_STEPS]  = out_rdy;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (out_rdy) begin
      out_v <= dv_v[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (out_rdy && dv_v[DIV_STEPS]) begin
      out_item <= fin_item;
      // lost particles keep their coordinates
      out_x    <= fin_item.lost ? fin_item.x  : sat32(sum_x);
      out_y    <= fin_item.lost ? fin_item.y  : sat32(sum_y);
      out_ct   <= fin_item.lost ? fin_item.ct : sat32(sum_ct);
    end
  end

  assign out_valid = out_v;
  assign x_out     = out_x;
  assign px_out    = out_item.px;
  assign y_out     = out_y;
  assign py_out    = out_item.py;
  assign delta_out = out_item.delta;
  assign ct_out    = out_ct;
  assign lost_out  = out_item.lost;
  assign last_out  = out_item.last;

  // ---------------- checks
  // an empty output register means every stage can move
  assert property (@(posedge clk) disable iff (rst) !out_valid |-> in_ready)
    else $error("input stalled with an empty output register");

  // zero drift length leaves the positions alone
  assert property (@(posedge clk) disable iff (rst)
    out_valid && drift_length == '0 |->
      x_out == out_item.x && y_out == out_item.y && ct_out == out_item.ct)
    else $error("zero length drift moved the particle");

  // nothing comes out right after reset
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule
